@@ sv/spi_pkg.sv @@
// Shared widths, codes and types of the segment and plane intersection core.
`timescale 1ns / 1ps
package spi_pkg;
	localparam int CW = 32;
	localparam int FRAC = 16;
	localparam int NRM_W = 18;
	localparam int OFF_W = 32;
	localparam int TOL_W = 31;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int P_W = NRM_W + CW;
	localparam int H_W = P_W + 3;
	localparam int DEN_W = H_W + 1;
	localparam int D_W = CW + 1;
	localparam int QB = D_W;
	localparam int N_W = H_W + D_W;
	localparam int NLO = 32;
	localparam int NHI = H_W - NLO;
	localparam int AX_LAT = 3 + QB;

	localparam logic [CFG_IDX_W-1:0] REG_NX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NZ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd4;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_POINT = 2'd1;
	localparam logic [1:0] KIND_PLANE = 2'd2;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_START,
		MODE_FINISH,
		MODE_CROSS
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] e;
		logic dneg;
		logic [DEN_W-1:0] den;
	} side_t;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} res_t;
endpackage

@@ sv/spi_height.sv @@
// Two-stage signed height of one point above the configured plane.
`timescale 1ns / 1ps
module spi_height (
	input logic clk,
	input logic en,
	input logic signed [spi_pkg::NRM_W-1:0] nx,
	input logic signed [spi_pkg::NRM_W-1:0] ny,
	input logic signed [spi_pkg::NRM_W-1:0] nz,
	input logic signed [spi_pkg::OFF_W-1:0] off,
	input logic signed [spi_pkg::CW-1:0] px,
	input logic signed [spi_pkg::CW-1:0] py,
	input logic signed [spi_pkg::CW-1:0] pz,
	output logic signed [spi_pkg::H_W-1:0] h
);
	import spi_pkg::*;

	logic signed [P_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [H_W-1:0] h_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= P_W'(nx) * P_W'(px);
			py_s1 <= P_W'(ny) * P_W'(py);
			pz_s1 <= P_W'(nz) * P_W'(pz);
			h_s2 <= H_W'(px_s1) + H_W'(py_s1) + H_W'(pz_s1) - (H_W'(off) <<< FRAC);
		end
	end

	assign h = h_s2;
endmodule

@@ sv/spi_axis.sv @@
// One coordinate axis: scaling multiply, pipelined restoring divide and final point.
`timescale 1ns / 1ps
module spi_axis (
	input logic clk,
	input logic en,
	input spi_pkg::mode_t mode,
	input logic [spi_pkg::H_W-1:0] num,
	input logic [spi_pkg::DEN_W-1:0] den,
	input logic signed [spi_pkg::CW-1:0] s,
	input logic signed [spi_pkg::CW-1:0] e,
	output logic signed [spi_pkg::CW-1:0] coord
);
	import spi_pkg::*;

	side_t side_s1, side_s2;
	side_t side_sn [0:QB];
	logic [H_W-1:0] num_s1;
	logic [D_W-1:0] dmag_s1, dmag_s2;
	logic [NLO+D_W-1:0] plo_s2;
	logic [NHI+D_W-1:0] phi_s2;
	logic [DEN_W-1:0] rem_sn [0:QB];
	logic [QB-1:0] low_sn [0:QB];
	logic [QB-1:0] quo_sn [0:QB];
	logic signed [D_W-1:0] diff;
	logic [N_W-1:0] prod;
	logic signed [CW+1:0] sum;
	logic signed [CW+1:0] hi_lim, lo_lim;

	assign diff = D_W'(e) - D_W'(s);
	assign prod = (N_W'(phi_s2) << NLO) + N_W'(plo_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.mode <= mode;
			side_s1.s <= s;
			side_s1.e <= e;
			side_s1.dneg <= diff[D_W-1];
			side_s1.den <= den;
			num_s1 <= num;
			dmag_s1 <= diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
			side_s2 <= side_s1;
			dmag_s2 <= dmag_s1;
			plo_s2 <= (NLO+D_W)'(num_s1[NLO-1:0]) * (NLO+D_W)'(dmag_s1);
			phi_s2 <= (NHI+D_W)'(num_s1[H_W-1:NLO]) * (NHI+D_W)'(dmag_s1);
			side_sn[0] <= side_s2;
			rem_sn[0] <= DEN_W'(prod[N_W-1:QB]);
			low_sn[0] <= prod[QB-1:0];
			quo_sn[0] <= '0;
		end
	end

	// Each stage brings down one dividend bit and settles one quotient bit.
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic take;
		assign trial = {rem_sn[k], low_sn[k][QB-1]};
		assign take = trial >= {1'b0, side_sn[k].den};
		always_ff @(posedge clk) begin
			if (en) begin
				side_sn[k+1] <= side_sn[k];
				rem_sn[k+1] <= take ? DEN_W'(trial - {1'b0, side_sn[k].den})
					: DEN_W'(trial);
				low_sn[k+1] <= {low_sn[k][QB-2:0], 1'b0};
				quo_sn[k+1] <= {quo_sn[k][QB-2:0], take};
			end
		end
	end

	assign hi_lim = (CW+2)'({1'b0, {(CW-1){1'b1}}});
	assign lo_lim = -hi_lim - (CW+2)'(1);
	assign sum = side_sn[QB].dneg
		? (CW+2)'(side_sn[QB].s) - (CW+2)'({1'b0, quo_sn[QB]})
		: (CW+2)'(side_sn[QB].s) + (CW+2)'({1'b0, quo_sn[QB]});

	always_comb begin
		unique case (side_sn[QB].mode)
			MODE_START: coord = side_sn[QB].s;
			MODE_FINISH: coord = side_sn[QB].e;
			MODE_CROSS: begin
				if (sum > hi_lim) coord = hi_lim[CW-1:0];
				else if (sum < lo_lim) coord = lo_lim[CW-1:0];
				else coord = sum[CW-1:0];
			end
			default: coord = '0;
		endcase
	end
endmodule

@@ sv/segment_plane_intersect_core.sv @@
// Top level of the segment and plane intersection core.
`timescale 1ns / 1ps
// Takes one segment per clock while in_stall is low and returns one result per segment,
// in order. Two stages form the endpoint heights, two classify them against the
// tolerance, three scale the coordinate difference, and a 33-stage restoring divider,
// one quotient bit per stage, forms the crossing point on each axis. A one-entry skid
// buffer behind the output register keeps input flowing while a result waits; in_stall
// rises only once both are full. Plane registers may be written only while no segment
// is in flight.
module segment_plane_intersect_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [spi_pkg::CFG_IDX_W-1:0] cfg_idx,
	input logic [spi_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [spi_pkg::CW-1:0] start_x,
	input logic signed [spi_pkg::CW-1:0] start_y,
	input logic signed [spi_pkg::CW-1:0] start_z,
	input logic signed [spi_pkg::CW-1:0] finish_x,
	input logic signed [spi_pkg::CW-1:0] finish_y,
	input logic signed [spi_pkg::CW-1:0] finish_z,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] hit_kind,
	output logic signed [spi_pkg::CW-1:0] hit_x,
	output logic signed [spi_pkg::CW-1:0] hit_y,
	output logic signed [spi_pkg::CW-1:0] hit_z
);
	import spi_pkg::*;

	logic signed [NRM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [OFF_W-1:0] off_q;
	logic [TOL_W-1:0] tol_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CW-1:0] pt_s1 [0:5];
	logic signed [CW-1:0] pt_s2 [0:5];
	logic signed [CW-1:0] pt_s3 [0:5];
	logic signed [CW-1:0] pt_s4 [0:5];
	logic signed [H_W-1:0] hs, he;
	logic [H_W-1:0] ms_s3, me_s3;
	logic ns_s3, ne_s3;
	logic [H_W-1:0] tol_w;
	logic zs, ze;
	mode_t mode_s4;
	logic [1:0] kind_s4;
	logic [H_W-1:0] num_s4;
	logic [DEN_W-1:0] den_s4;
	logic v_sn [0:AX_LAT-1];
	logic [1:0] kind_sn [0:AX_LAT-1];
	logic signed [CW-1:0] cx, cy, cz;
	res_t res_new, out_q, skid_q;
	logic out_v_q, skid_full_q;
	logic push, pop;

	assign en = ~skid_full_q;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= NRM_W'(1) <<< FRAC;
			off_q <= '0;
			tol_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_NX: nx_q <= cfg_data[NRM_W-1:0];
				REG_NY: ny_q <= cfg_data[NRM_W-1:0];
				REG_NZ: nz_q <= cfg_data[NRM_W-1:0];
				REG_OFF: off_q <= cfg_data[OFF_W-1:0];
				REG_TOL: tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	spi_height u_hs (
		.clk(clk), .en(en), .nx(nx_q), .ny(ny_q), .nz(nz_q), .off(off_q),
		.px(start_x), .py(start_y), .pz(start_z), .h(hs)
	);
	spi_height u_he (
		.clk(clk), .en(en), .nx(nx_q), .ny(ny_q), .nz(nz_q), .off(off_q),
		.px(finish_x), .py(finish_y), .pz(finish_z), .h(he)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < AX_LAT; i++) v_sn[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sn[0] <= v_s4;
			for (int i = 1; i < AX_LAT; i++) v_sn[i] <= v_sn[i-1];
		end
	end

	assign tol_w = H_W'(tol_q) << FRAC;
	assign zs = ms_s3 <= tol_w;
	assign ze = me_s3 <= tol_w;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1[0] <= start_x;
			pt_s1[1] <= start_y;
			pt_s1[2] <= start_z;
			pt_s1[3] <= finish_x;
			pt_s1[4] <= finish_y;
			pt_s1[5] <= finish_z;
			pt_s2 <= pt_s1;
			pt_s3 <= pt_s2;
			pt_s4 <= pt_s3;
			ns_s3 <= hs[H_W-1];
			ne_s3 <= he[H_W-1];
			ms_s3 <= hs[H_W-1] ? H_W'(-hs) : H_W'(hs);
			me_s3 <= he[H_W-1] ? H_W'(-he) : H_W'(he);
			num_s4 <= ms_s3;
			den_s4 <= DEN_W'(ms_s3) + DEN_W'(me_s3);
			if (zs && ze) begin
				kind_s4 <= KIND_PLANE;
				mode_s4 <= MODE_NONE;
			end else if (zs) begin
				kind_s4 <= KIND_POINT;
				mode_s4 <= MODE_START;
			end else if (ze) begin
				kind_s4 <= KIND_POINT;
				mode_s4 <= MODE_FINISH;
			end else if (ns_s3 != ne_s3) begin
				kind_s4 <= KIND_POINT;
				mode_s4 <= MODE_CROSS;
			end else begin
				kind_s4 <= KIND_NONE;
				mode_s4 <= MODE_NONE;
			end
			kind_sn[0] <= kind_s4;
			for (int i = 1; i < AX_LAT; i++) kind_sn[i] <= kind_sn[i-1];
		end
	end

	spi_axis u_ax (
		.clk(clk), .en(en), .mode(mode_s4), .num(num_s4), .den(den_s4),
		.s(pt_s4[0]), .e(pt_s4[3]), .coord(cx)
	);
	spi_axis u_ay (
		.clk(clk), .en(en), .mode(mode_s4), .num(num_s4), .den(den_s4),
		.s(pt_s4[1]), .e(pt_s4[4]), .coord(cy)
	);
	spi_axis u_az (
		.clk(clk), .en(en), .mode(mode_s4), .num(num_s4), .den(den_s4),
		.s(pt_s4[2]), .e(pt_s4[5]), .coord(cz)
	);

	assign res_new = '{kind: kind_sn[AX_LAT-1], x: cx, y: cy, z: cz};
	assign push = en & v_sn[AX_LAT-1];
	assign pop = out_v_q & ~out_stall;

	// The skid entry catches the item that leaves the pipeline while the output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_v_q || pop) begin
			out_v_q <= skid_full_q | push;
			skid_full_q <= 1'b0;
		end else if (push) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			out_q <= skid_full_q ? skid_q : res_new;
		end else if (push) begin
			skid_q <= res_new;
		end
	end

	assign out_valid = out_v_q;
	assign hit_kind = out_q.kind;
	assign hit_x = out_q.x;
	assign hit_y = out_q.y;
	assign hit_z = out_q.z;
endmodule

@@ tb/segment_plane_intersect_core_tb.sv @@
// Self-checking testbench for the segment and plane intersection core.
`timescale 1ns / 1ps
module segment_plane_intersect_core_tb;
	import spi_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic signed [CW-1:0] sx, sy, sz, fx, fy, fz;
	} seg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CW-1:0] finish_x = '0, finish_y = '0, finish_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] hit_kind;
	logic signed [CW-1:0] hit_x, hit_y, hit_z;

	// Plane registers as the block should hold them.
	logic signed [NRM_W-1:0] plane_nx = '0, plane_ny = '0, plane_nz = 18'sd65536;
	logic signed [OFF_W-1:0] plane_off = '0;
	logic [TOL_W-1:0] plane_tol = '0;

	seg_t pending_segs[$];
	seg_t cur_seg;
	res_t expected_hits[$];
	int gap_left = 0, stall_left = 0;
	bit sender_idles = 1'b1, receiver_idles = 1'b1;
	int mismatches = 0, hits_checked = 0, segs_sent = 0;
	int kind_seen[3] = '{0, 0, 0};

	segment_plane_intersect_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [127:0] height_of(logic signed [CW-1:0] px,
			logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
		logic signed [127:0] nx, ny, nz, ax, ay, az, off;
		nx = plane_nx; ny = plane_ny; nz = plane_nz;
		ax = px; ay = py; az = pz; off = plane_off;
		return nx * ax + ny * ay + nz * az - off * 128'sd65536;
	endfunction

	function automatic int side_of(logic signed [127:0] h);
		logic signed [127:0] tol;
		tol = {97'b0, plane_tol} * 128'sd65536;
		if (h < 0)
			return (-h > tol) ? -1 : 0;
		return (h > tol) ? 1 : 0;
	endfunction

	function automatic res_t predict_hit(seg_t g);
		logic signed [127:0] hs, he, diff;
		logic [127:0] num, den, q;
		longint sp[3], fp[3], d, ad, p;
		logic [61:0] step;
		int cs, ce;
		res_t r;
		hs = height_of(g.sx, g.sy, g.sz);
		he = height_of(g.fx, g.fy, g.fz);
		cs = side_of(hs);
		ce = side_of(he);
		sp = '{g.sx, g.sy, g.sz};
		fp = '{g.fx, g.fy, g.fz};
		r = '{kind: KIND_NONE, x: '0, y: '0, z: '0};
		if (cs == 0 && ce == 0) begin
			r.kind = KIND_PLANE;
		end else if (cs == 0) begin
			r = '{kind: KIND_POINT, x: g.sx, y: g.sy, z: g.sz};
		end else if (ce == 0) begin
			r = '{kind: KIND_POINT, x: g.fx, y: g.fy, z: g.fz};
		end else if (cs != ce) begin
			diff = hs - he;
			den = (diff < 0) ? -diff : diff;
			num = (hs < 0) ? -hs : hs;
			r.kind = KIND_POINT;
			for (int i = 0; i < 3; i++) begin
				d = fp[i] - sp[i];
				ad = (d < 0) ? -d : d;
				q = (num * 128'(ad)) / den;
				step = q[61:0];
				p = (d >= 0) ? sp[i] + longint'(step) : sp[i] - longint'(step);
				if (p > 64'sd2147483647) p = 64'sd2147483647;
				if (p < -64'sd2147483648) p = -64'sd2147483648;
				if (i == 0) r.x = p[CW-1:0];
				else if (i == 1) r.y = p[CW-1:0];
				else r.z = p[CW-1:0];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sender: holds each item until it is taken, then draws the next from the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_hits.push_back(predict_hit(cur_seg));
				segs_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_segs.size() > 0) begin
					cur_seg = pending_segs.pop_front();
					start_x <= cur_seg.sx; start_y <= cur_seg.sy; start_z <= cur_seg.sz;
					finish_x <= cur_seg.fx; finish_y <= cur_seg.fy; finish_z <= cur_seg.fz;
					in_valid <= 1'b1;
					gap_left <= sender_idles ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Receiver: random stall and comparison of every accepted result.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					$display("MISMATCH at %0t: result with nothing outstanding", $realtime);
					mismatches++;
				end else begin
					want = expected_hits.pop_front();
					if (hit_kind != want.kind) report_mismatch("hit_kind", hit_kind, want.kind);
					if (hit_x != want.x) report_mismatch("hit_x", hit_x, want.x);
					if (hit_y != want.y) report_mismatch("hit_y", hit_y, want.y);
					if (hit_z != want.z) report_mismatch("hit_z", hit_z, want.z);
					if (want.kind <= KIND_PLANE) kind_seen[want.kind]++;
					hits_checked++;
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				stall_left <= receiver_idles ? pick_gap() : 0;
				out_stall <= 1'b0;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NX: plane_nx = val[NRM_W-1:0];
			REG_NY: plane_ny = val[NRM_W-1:0];
			REG_NZ: plane_nz = val[NRM_W-1:0];
			REG_OFF: plane_off = val[OFF_W-1:0];
			REG_TOL: plane_tol = val[TOL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_plane(int nx, int ny, int nz, logic [31:0] off, logic [31:0] tol);
		write_reg(REG_NX, nx);
		write_reg(REG_NY, ny);
		write_reg(REG_NZ, nz);
		write_reg(REG_OFF, off);
		write_reg(REG_TOL, tol);
	endtask

	// Waits until every item is taken and answered, then lets the pipeline settle.
	task automatic drain();
		while (pending_segs.size() > 0 || in_valid || expected_hits.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_seg(int sx, int sy, int sz, int fx, int fy, int fz);
		pending_segs.push_back('{sx, sy, sz, fx, fy, fz});
	endtask

	function automatic int rand_coord(int style);
		case (style)
			0: return int'($urandom);
			1: return $urandom_range(0, 2097152) - 1048576;
			default: return $urandom_range(0, 64) - 32;
		endcase
	endfunction

	task automatic add_random_segs(int count);
		int style, sx, sy, sz;
		for (int n = 0; n < count; n++) begin
			style = $urandom_range(0, 9);
			if (style < 2) begin
				add_seg(int'($urandom), int'($urandom), int'($urandom),
					int'($urandom), int'($urandom), int'($urandom));
			end else if (style < 8) begin
				add_seg(rand_coord(1), rand_coord(1), rand_coord(1),
					rand_coord(1), rand_coord(1), rand_coord(1));
			end else if (style < 9) begin
				add_seg(rand_coord(2), rand_coord(2), rand_coord(2),
					rand_coord(2), rand_coord(2), rand_coord(2));
			end else begin
				// A segment of zero length.
				sx = rand_coord(1); sy = rand_coord(1); sz = rand_coord(1);
				add_seg(sx, sy, sz, sx, sy, sz);
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset plane is z = 0 with no tolerance.
		add_seg(0, 0, 65536, 0, 0, -65536);
		add_seg(100, 200, 0, 300, 400, 500);
		add_seg(100, 200, 500, 300, 400, 0);
		add_seg(7, 8, 0, -9, -10, 0);
		add_seg(1, 2, 3, 4, 5, 6);
		add_seg(1, 2, -3, 4, 5, -6);
		add_seg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h80000000);
		add_seg(32'h80000000, 32'h7fffffff, -1, 32'h7fffffff, 32'h80000000, 1);
		add_seg(5, 5, 1, 5, 5, 1);
		add_seg(0, 0, 1, 32'h7fffffff, 32'h80000000, -1);
		drain();
		write_reg(REG_SPARE, 32'hffffffff);
		set_plane(-65536, 65536, -65536, 32'h7fffffff, 32'h7fffffff);
		add_seg(1, 2, 3, 4, 5, 6);
		add_seg(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff);
		drain();
		set_plane(65536, 0, 0, 32'h80000000, 0);
		add_seg(32'h80000000, 3, 4, 32'h7fffffff, 5, 6);
		add_seg(32'h80000000, 3, 4, 32'h80000001, 5, 6);
		add_seg(32'h80000001, 3, 4, 32'h80000000, 5, 6);
		drain();
		set_plane(0, 0, 65536, 0, 10);
		add_seg(0, 0, 10, 5, 5, -100);
		add_seg(0, 0, 11, 5, 5, -100);
		add_seg(0, 0, -10, 5, 5, 10);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			sender_idles = (ph % 4 != 1);
			receiver_idles = (ph % 4 != 2);
			if (ph == 0)
				set_plane(0, 0, 65536, 0, 0);
			else if (ph == 1)
				set_plane(65536, 65536, 65536, 32'h7fffffff, 0);
			else if (ph == 2)
				set_plane(-65536, -65536, -65536, 32'h80000000, 32'h7fffffff);
			else
				set_plane($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
					$urandom_range(0, 131072) - 65536, $urandom,
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 40) :
					$urandom_range(0, 2000000));
			add_random_segs(160);
			drain();
		end

		$display("Sent %0d segments through 16 plane settings and checked %0d results.",
			segs_sent, hits_checked);
		$display("Outcomes: %0d misses, %0d single points, %0d segments lying in the plane.",
			kind_seen[0], kind_seen[1], kind_seen[2]);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d results outstanding.", expected_hits.size());
		$display("Test completed with failures");
		$finish;
	end
endmodule
